/* rtl/otec_pkg.sv */
package otec_pkg;

    localparam int COUNT_BITS_DEFAULT = 24;
    localparam int TOTAL_W = 24;

    localparam logic [7:0] CHR_V     = 8'h76;
    localparam logic [7:0] CHR_F     = 8'h66;
    localparam logic [7:0] CHR_T     = 8'h74;
    localparam logic [7:0] CHR_N     = 8'h6E;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;

    typedef enum logic [1:0] {
        LINE_START   = 2'd0,
        LINE_AFTER_V = 2'd1,
        LINE_DISCARD = 2'd2
    } line_phase_t;

    typedef enum logic [1:0] {
        SCAN_IDLE   = 2'd0,
        SCAN_BLANKS = 2'd1,
        SCAN_COUNT  = 2'd2,
        SCAN_DONE   = 2'd3
    } scan_phase_t;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_END_AFTER_V = 2'd1;
    localparam logic [1:0] ST_END_IN_FACE = 2'd2;
    localparam logic [1:0] ST_SLASHES     = 2'd3;

    localparam logic [2:0] FK_UNDEF    = 3'd0;
    localparam logic [2:0] FK_POS      = 3'd1;
    localparam logic [2:0] FK_POS_UV   = 3'd2;
    localparam logic [2:0] FK_POS_NRM  = 3'd3;
    localparam logic [2:0] FK_POS_UV_N = 3'd4;

    localparam int CNT_POS  = 0;
    localparam int CNT_UV   = 1;
    localparam int CNT_NRM  = 2;
    localparam int CNT_FACE = 3;

endpackage

/* rtl/obj_text_element_counter.sv */
// Result: the result word is registered and appears on the master side in the cycle
//   after the end-of-file word (tlast) is accepted; plain bytes produce no word.
// Throughput: one input word per cycle; all line and face-scan state updates together
//   for each accepted word, the only stall is a full result register not taken.
// Reset: aresetn is synchronous, active low; it clears the counters, both
//   phase trackers and the error latch and empties the result register.
module obj_text_element_counter #(
    parameter int COUNT_BITS = otec_pkg::COUNT_BITS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] text_byte
    input  logic         s_tlast,   // end_marker
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [2:0] face_kind, [26:3] position_total,
                                    // [50:27] texcoord_total, [74:51] normal_total,
                                    // [98:75] face_total, [103:99] zero
    output logic [1:0]   m_tuser    // [1:0] status
);
    import otec_pkg::*;

    typedef logic [COUNT_BITS-1:0] cnt_t;

    // Parse state
    line_phase_t line_phase_reg, line_phase_next;
    scan_phase_t scan_phase_reg, scan_phase_next;
    logic [1:0]  slash_tally_reg, slash_tally_next;
    logic        last_slash_reg, last_slash_next;
    logic        adjacent_reg, adjacent_next;
    logic [2:0]  face_kind_reg, face_kind_next;
    logic [1:0]  error_reg, error_next;
    cnt_t        count_reg [4];
    cnt_t        count_next [4];

    // Result register
    logic         m_tvalid_reg, m_tvalid_next;
    logic [103:0] m_tdata_reg, m_tdata_next;
    logic [1:0]   m_tuser_reg, m_tuser_next;

    logic               accept;
    logic [7:0]         b;
    logic [1:0]         status;
    logic [TOTAL_W-1:0] wide [4];

    // Take a new word whenever the result register is empty or being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Low 24 bits of each counter, zero-extended when counters are narrower.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            wide[i] = TOTAL_W'(count_reg[i]);
        end
    end

    // End-of-file status: a latched error wins, then a face token still open wins over a dangling 'v'.
    always_comb begin
        status = error_reg;
        if (error_reg == ST_OK) begin
            if (scan_phase_reg == SCAN_BLANKS || scan_phase_reg == SCAN_COUNT) begin
                status = ST_END_IN_FACE;
            end else if (line_phase_reg == LINE_AFTER_V) begin
                status = ST_END_AFTER_V;
            end
        end
    end

    always_comb begin
        line_phase_next  = line_phase_reg;
        scan_phase_next  = scan_phase_reg;
        slash_tally_next = slash_tally_reg;
        last_slash_next  = last_slash_reg;
        adjacent_next    = adjacent_reg;
        face_kind_next   = face_kind_reg;
        error_next       = error_reg;
        for (int i = 0; i < 4; i++) begin
            count_next[i] = count_reg[i];
        end

        // Drop the result once taken.
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (accept && s_tlast) begin
            // Emit the result and return to the start-of-file state.
            m_tvalid_next = 1'b1;
            m_tuser_next  = status;
            if (status == ST_OK) begin
                m_tdata_next = {5'd0, wide[CNT_FACE], wide[CNT_NRM],
                                wide[CNT_UV], wide[CNT_POS], face_kind_reg};
            end else begin
                m_tdata_next = '0;
            end
            line_phase_next  = LINE_START;
            scan_phase_next  = SCAN_IDLE;
            slash_tally_next = 2'd0;
            last_slash_next  = 1'b0;
            adjacent_next    = 1'b0;
            face_kind_next   = FK_UNDEF;
            error_next       = ST_OK;
            for (int i = 0; i < 4; i++) begin
                count_next[i] = '0;
            end
        end else if (accept && error_reg == ST_OK) begin
            // Face-token scanner
            case (scan_phase_reg)
                SCAN_BLANKS: begin
                    if (b != CHR_SPACE && b != CHR_TAB) begin
                        scan_phase_next = SCAN_COUNT;
                    end
                end
                SCAN_COUNT: begin
                    if (b == CHR_SPACE) begin
                        scan_phase_next = SCAN_DONE;
                        case (slash_tally_reg)
                            2'd0:    face_kind_next = FK_POS;
                            2'd1:    face_kind_next = FK_POS_UV;
                            2'd2:    face_kind_next = adjacent_reg ? FK_POS_NRM
                                                                   : FK_POS_UV_N;
                            default: error_next = ST_SLASHES;
                        endcase
                    end else if (b == CHR_SLASH) begin
                        if (last_slash_reg) begin
                            adjacent_next = 1'b1;
                        end
                        last_slash_next = 1'b1;
                        if (slash_tally_reg != 2'd3) begin
                            slash_tally_next = slash_tally_reg + 2'd1;
                        end
                    end else begin
                        last_slash_next = 1'b0;
                    end
                end
                default: ;
            endcase

            // Line classifier, skipped when the scanner just latched an error
            if (error_next == ST_OK) begin
                unique case (line_phase_reg)
                    LINE_START: begin
                        if (b == CHR_V) begin
                            line_phase_next = LINE_AFTER_V;
                        end else begin
                            if (b == CHR_F) begin
                                if (scan_phase_reg == SCAN_IDLE) begin
                                    scan_phase_next = SCAN_BLANKS;
                                end
                                if (count_reg[CNT_FACE] != '1) begin
                                    count_next[CNT_FACE] = count_reg[CNT_FACE] + cnt_t'(1);
                                end
                            end
                            line_phase_next = LINE_DISCARD;
                        end
                    end
                    LINE_AFTER_V: begin
                        if (b == CHR_SPACE && count_reg[CNT_POS] != '1) begin
                            count_next[CNT_POS] = count_reg[CNT_POS] + cnt_t'(1);
                        end
                        if (b == CHR_T && count_reg[CNT_UV] != '1) begin
                            count_next[CNT_UV] = count_reg[CNT_UV] + cnt_t'(1);
                        end
                        if (b == CHR_N && count_reg[CNT_NRM] != '1) begin
                            count_next[CNT_NRM] = count_reg[CNT_NRM] + cnt_t'(1);
                        end
                        line_phase_next = LINE_DISCARD;
                    end
                    default: begin
                        if (b == CHR_LF) begin
                            line_phase_next = LINE_START;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_phase_reg  <= LINE_START;
            scan_phase_reg  <= SCAN_IDLE;
            slash_tally_reg <= 2'd0;
            last_slash_reg  <= 1'b0;
            adjacent_reg    <= 1'b0;
            face_kind_reg   <= FK_UNDEF;
            error_reg       <= ST_OK;
            for (int i = 0; i < 4; i++) begin
                count_reg[i] <= '0;
            end
            m_tvalid_reg    <= 1'b0;
        end else begin
            line_phase_reg  <= line_phase_next;
            scan_phase_reg  <= scan_phase_next;
            slash_tally_reg <= slash_tally_next;
            last_slash_reg  <= last_slash_next;
            adjacent_reg    <= adjacent_next;
            face_kind_reg   <= face_kind_next;
            error_reg       <= error_next;
            for (int i = 0; i < 4; i++) begin
                count_reg[i] <= count_next[i];
            end
            m_tvalid_reg    <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule
